// ===== hw/rtl/pit_pkg.sv =====
// Shared types and constants of the page idle age tracker.
`timescale 1ns / 1ps

package pit_pkg;

    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_ROUND = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_RESET = 2'd3;

    localparam int KINDS      = 16;
    localparam int NBUCKETS   = 8;
    localparam int HIST_BANK  = KINDS * NBUCKETS;
    localparam int HIST_DEPTH = 2 * HIST_BANK;

    typedef logic [7:0][7:0] t_edges;

    localparam t_edges EDGE_RESET = {8'd240, 8'd120, 8'd60, 8'd30,
                                     8'd15, 8'd5, 8'd2, 8'd1};

    typedef struct packed {
        logic [7:0] new_age;
        logic       early;
        logic       refs_checked;
        logic       set_idle;
        logic       hist_en;
        logic [2:0] bucket;
    } t_decision;

endpackage

// ===== hw/rtl/pit_decide.sv =====
// Idle decision, saturating age update and bucket lookup for one scanned page.
`timescale 1ns / 1ps

module pit_decide #(
    parameter int AGE_MAX = 255
) (
    input  logic [7:0]        i_age,
    input  logic              i_on_lru,
    input  logic              i_idle_mark,
    input  logic              i_referenced,
    input  logic              i_ref_ok,
    input  logic              i_still_on_lru,
    input  logic [2:0]        i_phase,
    input  pit_pkg::t_edges   i_edges,
    output pit_pkg::t_decision o_dec
);

    logic due;
    logic idle;
    logic [2:0] bkt;

    always_comb begin
        if (i_age == 8'd0) begin
            due = i_phase[0];
        end else if (i_age < 8'd4) begin
            due = 1'b1;
        end else if (i_age < 8'd8) begin
            due = i_phase[0];
        end else if (i_age < 8'd16) begin
            due = (i_phase[1:0] == 2'b11);
        end else begin
            due = (i_phase == 3'b111);
        end
    end

    always_comb begin
        o_dec = '0;
        idle  = 1'b0;
        bkt   = 3'd7;
        if (!i_on_lru) begin
            o_dec.early = 1'b1;
        end else begin
            if (i_idle_mark && due) begin
                o_dec.refs_checked = 1'b1;
                if (!(i_ref_ok && i_still_on_lru)) begin
                    o_dec.early = 1'b1;
                end else begin
                    idle = !i_referenced;
                end
            end else if (i_idle_mark) begin
                idle = (i_age != 8'd0);
            end
            if (!o_dec.early) begin
                if (idle) begin
                    o_dec.new_age = (i_age < 8'(AGE_MAX)) ? i_age + 8'd1 : 8'(AGE_MAX);
                    // First upper edge above the age picks the bucket below it.
                    for (int k = 7; k >= 1; k--) begin
                        if (o_dec.new_age < i_edges[k]) begin
                            bkt = 3'(k - 1);
                        end
                    end
                    o_dec.bucket  = bkt;
                    o_dec.hist_en = (o_dec.new_age >= i_edges[0]);
                end else begin
                    o_dec.set_idle = i_ref_ok && i_still_on_lru;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/page_idle_age_tracker.sv =====
// Top level of the page idle age tracker: sequencer, age memory and histograms.
`timescale 1ns / 1ps

// A scan reduces the page number to a slot when PAGE_COUNT is below 65536, reads its age,
// writes the new age, then 2^order - 1 tail entries unless it ends early, and adds to the
// histogram when the page is counted. A read fetches one bin of the stable bank; a
// round-done clears one histogram bank. One command at a time; the single age memory port
// sets the pace. Reset and reset-all clear the age memory and both histogram banks, one
// entry per cycle, while busy stays high. The receiver cannot stall results.
module page_idle_age_tracker #(
    parameter int PAGE_COUNT     = 65536,
    parameter int AGE_MAX        = 255,
    parameter int MAX_HUGE_ORDER = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_page_number,
    input  logic        i_page_valid,
    input  logic        i_on_lru,
    input  logic        i_idle_mark,
    input  logic        i_referenced,
    input  logic        i_ref_ok,
    input  logic        i_still_on_lru,
    input  logic [3:0]  i_page_kind,
    input  logic [3:0]  i_huge_order,
    input  logic [2:0]  i_bucket_index,
    output logic        o_done,
    output logic [7:0]  o_new_age,
    output logic [9:0]  o_pages_advanced,
    output logic        o_set_idle_mark,
    output logic        o_refs_checked,
    output logic [31:0] o_count_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Address width of the age memory and length of the clearing pass.
    localparam int AW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CLR_N  = (PAGE_COUNT > 256) ? PAGE_COUNT : 256;
    localparam int CW     = $clog2(CLR_N);
    localparam bit NEED_MOD = (PAGE_COUNT < 65536);
    localparam int HW     = $clog2(pit_pkg::HIST_DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_ARD   = 4'd3;
    localparam logic [3:0] ST_DEC   = 4'd4;
    localparam logic [3:0] ST_TAIL  = 4'd5;
    localparam logic [3:0] ST_HADD  = 4'd6;
    localparam logic [3:0] ST_HRD   = 4'd7;
    localparam logic [3:0] ST_SWEEP = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic        r_from_cmd;
    logic [15:0] r_rem;
    logic [3:0]  r_k;
    logic [AW-1:0] r_addr;
    logic [8:0]  r_tail_left;
    logic [3:0]  r_order;
    logic [15:0] r_pfn;
    logic        r_on_lru, r_idle_mark, r_referenced, r_ref_ok, r_still;
    logic [3:0]  r_kind;
    logic        r_bank;
    logic [31:0] r_round;
    logic        r_hadd;
    logic [HW-1:0] r_bin;
    logic [7:0]  r_age_q;
    logic [31:0] r_hist_q;
    pit_pkg::t_edges r_edges;

    logic [7:0]  r_new_age;
    logic [9:0]  r_nr;
    logic        r_set_idle, r_refs;
    logic [31:0] r_count;

    logic [7:0]  age_mem [PAGE_COUNT];
    logic [31:0] hist_mem [pit_pkg::HIST_DEPTH];

    pit_pkg::t_decision dec;
    logic [15:0] pfn_shift;
    logic [2:0]  phase;
    logic [31:0] mod_sub;
    logic [AW-1:0] addr_next;
    logic [9:0]  nr_full;
    logic [3:0]  order_sat;
    logic        age_we;
    logic [AW-1:0] age_waddr;
    logic [7:0]  age_wdata;
    logic        hist_we, hist_re;
    logic [HW-1:0] hist_waddr, hist_raddr;
    logic [31:0] hist_wdata;
    logic [32:0] hist_sum;
    logic        clr_last, sweep_last;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done           = (r_state == ST_DONE);
    assign o_new_age        = r_new_age;
    assign o_pages_advanced = r_nr;
    assign o_set_idle_mark  = r_set_idle;
    assign o_refs_checked   = r_refs;
    assign o_count_value    = r_count;

    // The sampling phase only needs the low three bits of the sum.
    assign pfn_shift = r_pfn >> r_order;
    assign phase     = pfn_shift[2:0] + r_round[2:0];
    assign mod_sub   = 32'(PAGE_COUNT) << r_k;
    assign addr_next = (r_addr == AW'(PAGE_COUNT - 1)) ? '0 : r_addr + AW'(1);
    assign nr_full   = 10'd1 << r_order;
    assign order_sat = (i_huge_order > 4'(MAX_HUGE_ORDER)) ? 4'(MAX_HUGE_ORDER) : i_huge_order;
    assign hist_sum  = {1'b0, r_hist_q} + 33'(r_nr);
    assign clr_last  = (r_cnt == CW'(CLR_N - 1));
    assign sweep_last = (r_cnt[6:0] == 7'(pit_pkg::HIST_BANK - 1));

    pit_decide #(
        .AGE_MAX(AGE_MAX)
    ) u_decide (
        .i_age         (r_age_q),
        .i_on_lru      (r_on_lru),
        .i_idle_mark   (r_idle_mark),
        .i_referenced  (r_referenced),
        .i_ref_ok      (r_ref_ok),
        .i_still_on_lru(r_still),
        .i_phase       (phase),
        .i_edges       (r_edges),
        .o_dec         (dec)
    );

    // Next state of the command sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = r_from_cmd ? ST_DONE : ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    case (i_command)
                        pit_pkg::CMD_SCAN: begin
                            if (!i_page_valid) n_state = ST_DONE;
                            else n_state = NEED_MOD ? ST_MOD : ST_ARD;
                        end
                        pit_pkg::CMD_ROUND: n_state = ST_SWEEP;
                        pit_pkg::CMD_READ:  n_state = ST_HRD;
                        default:            n_state = ST_CLEAR;
                    endcase
                end
            end
            ST_MOD:   if (r_k == 4'd0) n_state = ST_ARD;
            ST_ARD:   n_state = ST_DEC;
            ST_DEC:   n_state = ST_TAIL;
            ST_TAIL: begin
                if (r_tail_left == 9'd0) n_state = r_hadd ? ST_HADD : ST_DONE;
            end
            ST_HADD:  n_state = ST_DONE;
            ST_HRD:   n_state = ST_DONE;
            ST_SWEEP: if (sweep_last) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Age memory write port: clearing pass, slot update and the tail walk.
    always_comb begin
        age_we    = 1'b0;
        age_waddr = r_addr;
        age_wdata = r_new_age;
        case (r_state)
            ST_CLEAR: begin
                age_we    = ({1'b0, r_cnt} < (CW + 1)'(PAGE_COUNT));
                age_waddr = r_cnt[AW-1:0];
                age_wdata = 8'd0;
            end
            ST_DEC: begin
                age_we    = 1'b1;
                age_wdata = dec.new_age;
            end
            ST_TAIL: begin
                age_we    = (r_tail_left != 9'd0);
                age_waddr = addr_next;
            end
            default: ;
        endcase
    end

    // Histogram memory: both banks in one array, the working bank selected by r_bank.
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_bin;
        hist_wdata = hist_sum[32] ? 32'hFFFF_FFFF : hist_sum[31:0];
        hist_re    = 1'b0;
        hist_raddr = {r_bank, r_kind, dec.bucket};
        case (r_state)
            ST_CLEAR: begin
                hist_we    = ({1'b0, r_cnt} < (CW + 1)'(pit_pkg::HIST_DEPTH));
                hist_waddr = r_cnt[HW-1:0];
                hist_wdata = '0;
            end
            ST_SWEEP: begin
                hist_we    = 1'b1;
                hist_waddr = {r_bank, r_cnt[6:0]};
                hist_wdata = '0;
            end
            ST_HADD: hist_we = 1'b1;
            ST_DEC:  hist_re = 1'b1;
            ST_IDLE: begin
                hist_re    = 1'b1;
                hist_raddr = {~r_bank, i_page_kind, i_bucket_index};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (age_we) age_mem[age_waddr] <= age_wdata;
        if (r_state == ST_ARD) r_age_q <= age_mem[AW'(r_rem)];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
        if (hist_re) r_hist_q <= hist_mem[hist_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_from_cmd <= 1'b0;
            r_bank     <= 1'b0;
            r_round    <= '0;
            r_edges    <= pit_pkg::EDGE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_edges[i_cfg_index] <= i_cfg_data;
            case (r_state)
                ST_CLEAR: r_cnt <= r_cnt + CW'(1);
                ST_SWEEP: r_cnt <= r_cnt + CW'(1);
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (start && (i_command == pit_pkg::CMD_ROUND)) begin
                        r_bank  <= ~r_bank;
                        r_round <= r_round + 32'd1;
                    end
                    if (start) r_from_cmd <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == ST_CLEAR && clr_last) r_from_cmd <= 1'b0;
        end
    end

    // Item fields and the result beat.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_pfn        <= i_page_number;
                    r_rem        <= i_page_number;
                    r_k          <= 4'd15;
                    r_order      <= order_sat;
                    r_on_lru     <= i_on_lru;
                    r_idle_mark  <= i_idle_mark;
                    r_referenced <= i_referenced;
                    r_ref_ok     <= i_ref_ok;
                    r_still      <= i_still_on_lru;
                    r_kind       <= i_page_kind;
                    r_new_age    <= '0;
                    r_set_idle   <= 1'b0;
                    r_refs       <= 1'b0;
                    r_count      <= '0;
                    r_hadd       <= 1'b0;
                    r_nr         <= (i_command == pit_pkg::CMD_SCAN) ? 10'd1 : 10'd0;
                end
            end
            ST_MOD: begin
                if ({16'd0, r_rem} >= mod_sub) r_rem <= r_rem - mod_sub[15:0];
                r_k <= r_k - 4'd1;
            end
            ST_ARD: r_addr <= AW'(r_rem);
            ST_DEC: begin
                r_new_age   <= dec.new_age;
                r_set_idle  <= dec.set_idle;
                r_refs      <= dec.refs_checked;
                r_hadd      <= dec.hist_en;
                r_bin       <= {r_bank, r_kind, dec.bucket};
                r_nr        <= dec.early ? 10'd1 : nr_full;
                r_tail_left <= dec.early ? 9'd0 : 9'(nr_full - 10'd1);
            end
            ST_TAIL: begin
                if (r_tail_left != 9'd0) begin
                    r_addr      <= addr_next;
                    r_tail_left <= r_tail_left - 9'd1;
                end
            end
            ST_HRD: r_count <= r_hist_q;
            default: ;
        endcase
    end

    // A result beat lasts exactly one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    // An accepted command always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Only a read command puts a nonzero count on the result.
    a_count_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_pages_advanced != 10'd0)) |-> (o_count_value == 32'd0))
        else $error("scan result carries a histogram count");

endmodule

// ===== tb/tb_page_idle_age_tracker.sv =====
// Self-checking testbench of the page idle age tracker with an age and histogram scoreboard.
`timescale 1ns / 1ps

module tb_page_idle_age_tracker;

    localparam int AGE_LIMIT = 255;
    localparam int ORDER_LIMIT = 9;
    // The clearing pass after reset or reset-all walks 65536 entries with busy high, so a
    // stall limit well above that still catches a hang quickly.
    localparam int STALL_LIMIT = 250000;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int PHASES = 5;
    localparam int CALM_ITEMS = 150;

    // One command beat as it is driven onto the block.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] page;
        logic        valid;
        logic        lru;
        logic        mark;
        logic        refd;
        logic        rok;
        logic        still;
        logic [3:0]  kind;
        logic [3:0]  order;
        logic [2:0]  bucket;
    } t_page_cmd;

    // One result beat, in the field order of the output ports.
    typedef struct packed {
        logic [7:0]  age;
        logic [9:0]  pages;
        logic        set_idle;
        logic        refs;
        logic [31:0] count;
    } t_scan_result;

    // Keeps its own copy of the age table, both histograms, the round counter and the
    // bucket edges, and predicts the result of every accepted command.
    class idle_age_scoreboard;
        logic [7:0]   age_mem [65536];
        logic [31:0]  work_bins [128];
        logic [31:0]  stable_bins [128];
        logic [31:0]  round_ctr;
        logic [7:0]   edges [8];
        t_scan_result expected_results [$];
        int           mismatches;
        int           results_seen;
        int           rounds_done;

        function new();
            foreach (age_mem[i]) age_mem[i] = '0;
            clear_hist();
            round_ctr = '0;
            for (int i = 0; i < 8; i++) edges[i] = pit_pkg::EDGE_RESET[i];
            mismatches = 0;
            results_seen = 0;
            rounds_done = 0;
        endfunction

        function void clear_hist();
            foreach (work_bins[i]) begin
                work_bins[i] = '0;
                stable_bins[i] = '0;
            end
        endfunction

        function void set_edge(int idx, logic [7:0] val);
            edges[idx] = val;
        endfunction

        function int bucket_of(logic [7:0] age);
            if (age < edges[0]) return -1;
            for (int b = 1; b < 8; b++) begin
                if (age < edges[b]) return b - 1;
            end
            return 7;
        endfunction

        // Sampling thins out as a page grows older: every other round at age zero,
        // always at ages one to three, then one in two, four and eight.
        function bit sample_due(logic [7:0] age, logic [15:0] page, int ord);
            logic [31:0] p;
            p = (32'(page) >> ord) + round_ctr;
            if (age == 0) return p[0];
            if (age < 4) return 1'b1;
            if (age < 8) return p[0];
            if (age < 16) return p[1:0] == 2'b11;
            return p[2:0] == 3'b111;
        endfunction

        function void note_command(t_page_cmd c);
            t_scan_result r;
            logic [7:0]   age;
            logic [32:0]  sum;
            bit           idle;
            bit           early;
            int           ord;
            int           nr;
            int           b;
            r = '0;
            case (c.cmd)
                pit_pkg::CMD_SCAN: begin
                    ord = (c.order > ORDER_LIMIT) ? ORDER_LIMIT : int'(c.order);
                    r.pages = 10'd1;
                    if (!c.valid) begin
                        // A missing frame leaves everything alone.
                    end else if (!c.lru) begin
                        age_mem[c.page] = '0;
                    end else begin
                        age = age_mem[c.page];
                        idle = 1'b0;
                        early = 1'b0;
                        if (c.mark) begin
                            if (sample_due(age, c.page, ord)) begin
                                r.refs = 1'b1;
                                if (!c.rok || !c.still) begin
                                    age_mem[c.page] = '0;
                                    early = 1'b1;
                                end else begin
                                    idle = !c.refd;
                                end
                            end else if (age > 0) begin
                                idle = 1'b1;
                            end
                        end
                        if (!early) begin
                            nr = 1 << ord;
                            if (idle) begin
                                if (age < AGE_LIMIT) age = age + 8'd1;
                                age_mem[c.page] = age;
                                b = bucket_of(age);
                                if (b >= 0) begin
                                    sum = 33'(work_bins[c.kind * 8 + b]) + 33'(nr);
                                    work_bins[c.kind * 8 + b] = sum[32] ? 32'hFFFF_FFFF
                                                                        : sum[31:0];
                                end
                            end else begin
                                age = '0;
                                age_mem[c.page] = '0;
                                r.set_idle = c.rok && c.still;
                            end
                            for (int i = 1; i < nr; i++) age_mem[16'(c.page + i)] = age;
                            r.age = age;
                            r.pages = 10'(nr);
                        end
                    end
                end
                pit_pkg::CMD_ROUND: begin
                    stable_bins = work_bins;
                    foreach (work_bins[i]) work_bins[i] = '0;
                    round_ctr = round_ctr + 32'd1;
                    rounds_done++;
                end
                pit_pkg::CMD_READ: begin
                    r.count = stable_bins[c.kind * 8 + c.bucket];
                end
                default: begin
                    foreach (age_mem[i]) age_mem[i] = '0;
                    clear_hist();
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(t_scan_result act);
            t_scan_result exp_r;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", act);
                return;
            end
            exp_r = expected_results.pop_front();
            if (exp_r.age !== act.age || exp_r.pages !== act.pages
                    || exp_r.set_idle !== act.set_idle || exp_r.refs !== act.refs
                    || exp_r.count !== act.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %p, got %p",
                             results_seen, exp_r, act);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [15:0] i_page_number;
    logic        i_page_valid;
    logic        i_on_lru;
    logic        i_idle_mark;
    logic        i_referenced;
    logic        i_ref_ok;
    logic        i_still_on_lru;
    logic [3:0]  i_page_kind;
    logic [3:0]  i_huge_order;
    logic [2:0]  i_bucket_index;
    logic        o_done;
    logic [7:0]  o_new_age;
    logic [9:0]  o_pages_advanced;
    logic        o_set_idle_mark;
    logic        o_refs_checked;
    logic [31:0] o_count_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    idle_age_scoreboard sb;
    int items_sent;
    int stall_cycles;

    page_idle_age_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_page_number(i_page_number),
        .i_page_valid(i_page_valid), .i_on_lru(i_on_lru), .i_idle_mark(i_idle_mark),
        .i_referenced(i_referenced), .i_ref_ok(i_ref_ok),
        .i_still_on_lru(i_still_on_lru), .i_page_kind(i_page_kind),
        .i_huge_order(i_huge_order), .i_bucket_index(i_bucket_index),
        .o_done(o_done), .o_new_age(o_new_age), .o_pages_advanced(o_pages_advanced),
        .o_set_idle_mark(o_set_idle_mark), .o_refs_checked(o_refs_checked),
        .o_count_value(o_count_value), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Results cannot be held off, so every strobed cycle is one result beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && sb != null)
            sb.check_result({o_new_age, o_pages_advanced, o_set_idle_mark,
                             o_refs_checked, o_count_value});
    end

    // The watchdog only counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("tb_page_idle_age_tracker: FAIL");
                $finish;
            end
        end
    end

    // Drives one command and returns at the edge that accepts it. Start stays high so that
    // a following command can go back to back; the caller lowers it for a gap.
    task automatic send_command(t_page_cmd c);
        start          <= 1'b1;
        i_command      <= c.cmd;
        i_page_number  <= c.page;
        i_page_valid   <= c.valid;
        i_on_lru       <= c.lru;
        i_idle_mark    <= c.mark;
        i_referenced   <= c.refd;
        i_ref_ok       <= c.rok;
        i_still_on_lru <= c.still;
        i_page_kind    <= c.kind;
        i_huge_order   <= c.order;
        i_bucket_index <= c.bucket;
        do @(posedge i_clk); while (busy);
        sb.note_command(c);
        items_sent++;
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Lets every expected result arrive and the block go quiet before anything else.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_edges(pit_pkg::t_edges e);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= e[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_edge(i, e[i]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_page_cmd scan_of(logic [15:0] page, logic [3:0] order,
                                          logic [5:0] flags, logic [3:0] kind);
        t_page_cmd c;
        c = '0;
        c.cmd = pit_pkg::CMD_SCAN;
        c.page = page;
        {c.valid, c.lru, c.mark, c.refd, c.rok, c.still} = flags;
        c.kind = kind;
        c.order = order;
        return c;
    endfunction

    function automatic t_page_cmd simple_of(logic [1:0] cmd, logic [3:0] kind,
                                            logic [2:0] bucket);
        t_page_cmd c;
        c = t_page_cmd'($urandom());
        c.cmd = cmd;
        c.kind = kind;
        c.bucket = bucket;
        return c;
    endfunction

    // Most random traffic is well-formed scans over a small pool of pages, so that ages
    // climb through every sampling band up to saturation; the rest is resets, rounds, reads and raw scan noise.
    function automatic t_page_cmd random_command();
        t_page_cmd c;
        int sel;
        int osel;
        c = t_page_cmd'({$urandom(), $urandom()});
        sel = $urandom_range(0, 999);
        if (sel < 2) begin
            c.cmd = pit_pkg::CMD_RESET;
        end else if (sel < 60) begin
            c.cmd = pit_pkg::CMD_ROUND;
        end else if (sel < 140) begin
            c.cmd = pit_pkg::CMD_READ;
            if ($urandom_range(0, 3) != 0) c.kind = 4'($urandom_range(0, 3));
        end else if (sel < 880) begin
            c.cmd = pit_pkg::CMD_SCAN;
            c.page = 16'($urandom_range(0, 7) * 16);
            c.valid = 1'b1;
            c.lru = ($urandom_range(0, 49) != 0);
            c.mark = ($urandom_range(0, 9) != 0);
            c.refd = ($urandom_range(0, 6) == 0);
            c.rok = ($urandom_range(0, 29) != 0);
            c.still = ($urandom_range(0, 29) != 0);
            c.kind = 4'($urandom_range(0, 3));
            osel = $urandom_range(0, 99);
            c.order = (osel < 80) ? 4'd0 : (osel < 97) ? 4'($urandom_range(1, 3))
                                                        : 4'($urandom_range(9, 15));
        end else begin
            c.cmd = pit_pkg::CMD_SCAN;
            if ($urandom_range(0, 9) != 0) c.order = 4'($urandom_range(0, 2));
        end
        return c;
    endfunction

    initial begin
        pit_pkg::t_edges phase_edges;
        t_page_cmd       directed [$];
        int              burst;

        sb = new();
        items_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = pit_pkg::CMD_SCAN;
        i_page_number = '0;
        i_page_valid = 1'b0;
        i_on_lru = 1'b0;
        i_idle_mark = 1'b0;
        i_referenced = 1'b0;
        i_ref_ok = 1'b0;
        i_still_on_lru = 1'b0;
        i_page_kind = '0;
        i_huge_order = '0;
        i_bucket_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: missing frame, page off the LRU, the sampled and unsampled paths,
        // failed reference, huge pages with saturated order and wrapping tails, then a
        // round, reads of both ends of the histogram, a full reset and one more round and read.
        directed.push_back(scan_of(16'h0000, 4'd0, 6'b011111, 4'd0));
        directed.push_back(scan_of(16'h0001, 4'd0, 6'b101111, 4'd15));
        directed.push_back(scan_of(16'h0001, 4'd0, 6'b111011, 4'd15));
        directed.push_back(scan_of(16'h0001, 4'd0, 6'b111011, 4'd15));
        directed.push_back(scan_of(16'h0001, 4'd0, 6'b111111, 4'd15));
        directed.push_back(scan_of(16'h0003, 4'd0, 6'b111001, 4'd3));
        directed.push_back(scan_of(16'h0003, 4'd0, 6'b111010, 4'd3));
        directed.push_back(scan_of(16'h0005, 4'd0, 6'b110011, 4'd2));
        directed.push_back(scan_of(16'h0005, 4'd0, 6'b111011, 4'd2));
        directed.push_back(scan_of(16'h0005, 4'd0, 6'b110011, 4'd2));
        directed.push_back(scan_of(16'hFFFF, 4'd9, 6'b111011, 4'd8));
        directed.push_back(scan_of(16'hFE00, 4'd15, 6'b111011, 4'd15));
        directed.push_back(scan_of(16'hFE00, 4'd15, 6'b111011, 4'd15));
        directed.push_back(scan_of(16'h0007, 4'd3, 6'b111011, 4'd1));
        directed.push_back(simple_of(pit_pkg::CMD_ROUND, 4'd0, 3'd0));
        directed.push_back(simple_of(pit_pkg::CMD_READ, 4'd15, 3'd0));
        directed.push_back(simple_of(pit_pkg::CMD_READ, 4'd15, 3'd7));
        directed.push_back(simple_of(pit_pkg::CMD_READ, 4'd0, 3'd0));
        directed.push_back(simple_of(pit_pkg::CMD_RESET, 4'd0, 3'd0));
        directed.push_back(simple_of(pit_pkg::CMD_ROUND, 4'd0, 3'd0));
        directed.push_back(simple_of(pit_pkg::CMD_READ, 4'd15, 3'd0));
        foreach (directed[i]) send_command(directed[i]);

        // Wait for everything outstanding before the first register change.
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: phase_edges = '0;
                1: phase_edges = {8{8'hFF}};
                2: for (int i = 0; i < 8; i++) phase_edges[i] = 8'($urandom());
                3: phase_edges = {8'd200, 8'd100, 8'd40, 8'd16, 8'd8, 8'd4, 8'd2, 8'd0};
                default: phase_edges = pit_pkg::EDGE_RESET;
            endcase
            write_edges(phase_edges);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Idle bursts fall at random against every stage of the work, except in
                // the final stretch, which runs back to back.
                if (!(ph == PHASES - 1 && n >= RANDOM_PER_PHASE - CALM_ITEMS)
                        && $urandom_range(0, 3) == 0) begin
                    burst = $urandom_range(1, 12);
                    idle_gap(burst);
                end
                send_command(random_command());
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d commands, %0d result beats and %0d scan rounds",
                 items_sent, sb.results_seen, sb.rounds_done);
        $display("bucket edge settings: all zero, all ones, random, rising and default");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_page_idle_age_tracker: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("tb_page_idle_age_tracker: FAIL");
        end
        $finish;
    end

endmodule
